/* rtl/palette_texture_mipmap_builder_core_assert.svh */
// assertion macros shared by the mip chain builder rtl
`ifndef PALETTE_TEXTURE_MIPMAP_BUILDER_CORE_ASSERT_SVH
`define PALETTE_TEXTURE_MIPMAP_BUILDER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PTMB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptmb assertion failed");

// consequent must hold in the cycle after the antecedent
`define PTMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptmb assertion failed");

`endif

/* rtl/ptmb_pkg.sv */
// shared constants, codes and types of the mip chain builder
`timescale 1ns / 1ps
package ptmb_pkg;

    localparam int MAX_SIZE_LOG2 = 8;
    localparam int PALETTE_DEPTH = 256;
    localparam int STORE_DEPTH   = ((1 << (2 * (MAX_SIZE_LOG2 + 1))) - 1) / 3;

    localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int ST_AW  = $clog2(STORE_DEPTH);
    localparam int LG_W   = 4;
    localparam int ADDR_W = 17;
    localparam int EXT_W  = (ADDR_W > 2 * MAX_SIZE_LOG2 + 2) ? ADDR_W : 2 * MAX_SIZE_LOG2 + 2;
    localparam int XY_W   = MAX_SIZE_LOG2;

    // input tdata layout
    localparam int IN_DATA_W = 96;
    localparam int OFF_ADDR  = 0;
    localparam int OFF_IDX   = 17;
    localparam int OFF_RED   = 25;
    localparam int OFF_GREEN = 33;
    localparam int OFF_BLUE  = 41;
    localparam int OFF_ALPHA = 49;
    localparam int OFF_DIR   = 57;

    // item kinds
    localparam logic [1:0] KIND_PAL   = 2'd0;
    localparam logic [1:0] KIND_PIX   = 2'd1;
    localparam logic [1:0] KIND_BUILD = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // source modes
    localparam logic [1:0] MODE_KEYED  = 2'd0;
    localparam logic [1:0] MODE_ALPHA  = 2'd1;
    localparam logic [1:0] MODE_DIRECT = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIPMAP_EN   = 2'd2;

    typedef struct packed {
        logic clr;
        logic add;
    } t_acc_ctl;

    // word count of a full chain for base edge 2**lg: binary 0101..01
    function automatic logic [EXT_W-1:0] chain_words(input logic [LG_W-1:0] lg);
        logic [EXT_W-1:0] res;
        res = '0;
        for (int i = 0; i <= MAX_SIZE_LOG2; i++) begin
            if (i <= int'(lg)) begin
                res[2 * i] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

/* rtl/palette_texture_mipmap_builder_core.sv */
// top level of the palette texture mip chain builder
//
// channel   direction  handshake              payload
// s         in         i_s_tvalid/o_s_tready  tdata fields, tuser kind
// m         out        o_m_tvalid/i_m_tready  tdata pixel_value, tuser status
// cfg       in         i_cfg_we               i_cfg_addr, i_cfg_wdata
//
// palette write, out-of-range item, disabled build: go from accept straight to S_DONE
// pixel write and read: pass through S_PIX or S_RD for the registered palette and store reads
// build: tap reads P00 to P11 then a write per reduced-level pixel, one store port access per tap
// a finished result waits in the output register while the next item is taken
// reset is synchronous active low and clears control and configuration only
`timescale 1ns / 1ps
`include "palette_texture_mipmap_builder_core_assert.svh"
module palette_texture_mipmap_builder_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tdata: address[16:0], color_index[24:17], red[32:25], green[40:33],
    //        blue[48:41], alpha[56:49], direct_color[88:57], zero fill above
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [ptmb_pkg::IN_DATA_W-1:0] i_s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]                     i_s_tuser,
    // tdata: pixel_value[31:0]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [31:0]                    o_m_tdata,
    // tuser: status[0]
    output logic [0:0]                     o_m_tuser,
    input  logic                           i_cfg_we,
    input  logic [ptmb_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [ptmb_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import ptmb_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PIX   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_BUILD = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // build phases: four tap reads then the write of the averaged word
    localparam logic [2:0] PH_P00 = 3'd0;
    localparam logic [2:0] PH_P01 = 3'd1;
    localparam logic [2:0] PH_P10 = 3'd2;
    localparam logic [2:0] PH_P11 = 3'd3;
    localparam logic [2:0] PH_WR  = 3'd4;

    // configuration
    logic [LG_W-1:0]  r_size_log2;
    logic [1:0]       r_source_mode;
    logic             r_mipmap_en;

    // sequencer and item registers
    logic [2:0]       r_state;
    logic [2:0]       r_phase;
    logic [ADDR_W-1:0] r_addr;
    logic             r_idx_ok;
    logic [7:0]       r_alpha;
    logic [31:0]      r_direct;
    logic [31:0]      r_res_value;
    logic             r_res_status;

    // build walk
    logic [LG_W-1:0]  r_lg;
    logic [ST_AW-1:0] r_base;
    logic [ST_AW-1:0] r_dst;
    logic [ST_AW-1:0] r_lvl_dst;
    logic [XY_W-1:0]  r_x;
    logic [XY_W-1:0]  r_y;

    // output register
    logic             r_out_valid;
    logic [31:0]      r_out_data;
    logic             r_out_status;

    // memories
    logic [23:0]      r_palette [PALETTE_DEPTH];
    logic [31:0]      r_store   [STORE_DEPTH];
    logic [23:0]      r_pal_q;
    logic [31:0]      r_st_q;

    // unpacked input transaction
    logic [1:0]       in_kind;
    logic [ADDR_W-1:0] in_addr;
    logic [7:0]       in_idx;
    logic [23:0]      in_rgb;

    logic             accept;
    logic             out_free;
    logic [LG_W-1:0]  eff_lg;
    logic [EXT_W-1:0] addr_ext;
    logic [EXT_W-1:0] area;
    logic             idx_in_range;
    logic [ST_AW-1:0] dims;
    logic [ST_AW-1:0] tap_off;
    logic [XY_W:0]    half;
    logic [XY_W-1:0]  last_idx;
    logic [23:0]      lookup;
    logic [31:0]      pix_word;
    logic [31:0]      avg_word;
    t_acc_ctl         acc_ctl;

    logic             pal_we;
    logic             st_we;
    logic [ST_AW-1:0] st_waddr;
    logic [31:0]      st_wdata;
    logic [ST_AW-1:0] st_raddr;

    assign in_kind  = i_s_tuser;
    assign in_addr  = i_s_tdata[OFF_ADDR +: ADDR_W];
    assign in_idx   = i_s_tdata[OFF_IDX +: 8];
    assign in_rgb   = {i_s_tdata[OFF_RED +: 8], i_s_tdata[OFF_GREEN +: 8],
                       i_s_tdata[OFF_BLUE +: 8]};

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    // size saturates at the largest supported base
    assign eff_lg   = (r_size_log2 > LG_W'(MAX_SIZE_LOG2)) ? LG_W'(MAX_SIZE_LOG2) : r_size_log2;
    assign addr_ext = EXT_W'(in_addr);
    assign area     = EXT_W'(1) << {eff_lg, 1'b0};
    assign idx_in_range = ({1'b0, in_idx} < 9'(PALETTE_DEPTH));

    // tap geometry of the current source level
    assign dims     = ST_AW'(1) << r_lg;
    assign half     = (XY_W + 1)'(1) << (r_lg - LG_W'(1));
    assign last_idx = XY_W'(half - (XY_W + 1)'(1));

    always_comb begin
        unique case (r_phase)
            PH_P01:  tap_off = ST_AW'(1);
            PH_P10:  tap_off = dims;
            PH_P11:  tap_off = dims + ST_AW'(1);
            default: tap_off = '0;
        endcase
    end

    // pixel resolve from the palette word read at accept
    always_comb begin
        lookup = r_idx_ok ? r_pal_q : 24'd0;
        case (r_source_mode)
            MODE_KEYED: pix_word = (lookup != 24'd0) ? {8'hff, lookup} : 32'd0;
            MODE_ALPHA: pix_word = {r_alpha, lookup};
            default:    pix_word = r_direct;
        endcase
    end

    ptmb_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .i_word  (r_st_q),
        .o_avg   (avg_word)
    );

    // memory port control
    always_comb begin
        pal_we   = 1'b0;
        st_we    = 1'b0;
        st_waddr = r_dst;
        st_wdata = avg_word;
        st_raddr = ST_AW'(EXT_W'(r_addr));
        acc_ctl  = '0;
        unique case (r_state)
            S_IDLE: begin
                st_raddr = ST_AW'(addr_ext);
                pal_we   = accept && (in_kind == KIND_PAL) && idx_in_range;
            end
            S_PIX: begin
                st_we    = 1'b1;
                st_waddr = ST_AW'(EXT_W'(r_addr));
                st_wdata = pix_word;
            end
            S_BUILD: begin
                st_raddr    = r_base + tap_off;
                acc_ctl.clr = (r_phase == PH_P00);
                acc_ctl.add = (r_phase == PH_P01) || (r_phase == PH_P10) ||
                              (r_phase == PH_P11);
                st_we       = (r_phase == PH_WR);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_palette[in_idx[PAL_AW-1:0]] <= in_rgb;
        end
        r_pal_q <= r_palette[in_idx[PAL_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_waddr] <= st_wdata;
        end
        r_st_q <= r_store[st_raddr];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2   <= LG_W'(8);
            r_source_mode <= MODE_KEYED;
            r_mipmap_en   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SIZE_LOG2:   r_size_log2   <= i_cfg_wdata[LG_W-1:0];
                CFG_SOURCE_MODE: r_source_mode <= i_cfg_wdata[1:0];
                CFG_MIPMAP_EN:   r_mipmap_en   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // item latch and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr       <= in_addr;
            r_idx_ok     <= idx_in_range;
            r_alpha      <= i_s_tdata[OFF_ALPHA +: 8];
            r_direct     <= i_s_tdata[OFF_DIR +: 32];
            r_res_value  <= 32'd0;
            unique case (in_kind)
                KIND_PAL:   r_res_status <= !idx_in_range;
                KIND_PIX:   r_res_status <= !(addr_ext < area);
                KIND_BUILD: r_res_status <= 1'b0;
                KIND_READ:  r_res_status <= !(addr_ext < chain_words(eff_lg));
            endcase
        end else if (r_state == S_RD) begin
            r_res_value <= r_st_q;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_P00;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_DONE;
                        unique case (in_kind)
                            KIND_PAL: begin
                            end
                            KIND_PIX: begin
                                if (addr_ext < area) begin
                                    r_state <= S_PIX;
                                end
                            end
                            KIND_BUILD: begin
                                // walk starts at the base, first level lands right after it
                                if (r_mipmap_en && (eff_lg != '0)) begin
                                    r_state   <= S_BUILD;
                                    r_phase   <= PH_P00;
                                    r_lg      <= eff_lg;
                                    r_base    <= '0;
                                    r_dst     <= ST_AW'(1) << {eff_lg, 1'b0};
                                    r_lvl_dst <= ST_AW'(1) << {eff_lg, 1'b0};
                                    r_x       <= '0;
                                    r_y       <= '0;
                                end
                            end
                            KIND_READ: begin
                                if (addr_ext < chain_words(eff_lg)) begin
                                    r_state <= S_RD;
                                end
                            end
                        endcase
                    end
                end
                S_PIX: r_state <= S_DONE;
                S_RD:  r_state <= S_DONE;
                S_BUILD: begin
                    if (r_phase != PH_WR) begin
                        r_phase <= r_phase + 3'd1;
                    end else begin
                        r_phase <= PH_P00;
                        r_dst   <= r_dst + ST_AW'(1);
                        if (r_x == last_idx) begin
                            r_x <= '0;
                            if (r_y == last_idx) begin
                                // level finished: it becomes the next source
                                r_y       <= '0;
                                r_lg      <= r_lg - LG_W'(1);
                                r_base    <= r_lvl_dst;
                                r_lvl_dst <= r_dst + ST_AW'(1);
                                if (r_lg == LG_W'(1)) begin
                                    r_state <= S_DONE;
                                end
                            end else begin
                                // skip the odd row of the source
                                r_y    <= r_y + XY_W'(1);
                                r_base <= r_base + ST_AW'(2) + dims;
                            end
                        end else begin
                            r_x    <= r_x + XY_W'(1);
                            r_base <= r_base + ST_AW'(2);
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register, loaded from the finished result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_data   <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_status;

    `PTMB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !o_s_tready)
    `PTMB_ASSERT_NOW(a_no_write_on_tap, i_clk, i_rst_n, (r_state == S_BUILD) && (r_phase != PH_WR), !st_we)
    `PTMB_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, (r_state == S_DONE) && out_free, o_m_tvalid && o_s_tready)

endmodule

/* rtl/ptmb_acc.sv */
// shared four-lane channel accumulator for the 2x2 box average
`timescale 1ns / 1ps
`include "palette_texture_mipmap_builder_core_assert.svh"
module ptmb_acc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptmb_pkg::t_acc_ctl i_ctl,
    input  logic [31:0]       i_word,
    output logic [31:0]       o_avg
);
    import ptmb_pkg::*;

    localparam int ACC_W = 10;

    logic [ACC_W-1:0] r_acc [4];
    logic [ACC_W-1:0] sum   [4];

    // one adder per byte lane, reused for every tap of every block
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sum[k]         = r_acc[k] + ACC_W'(i_word[8 * k +: 8]);
            o_avg[8 * k +: 8] = sum[k][ACC_W-1:2];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (i_ctl.clr) begin
                r_acc[k] <= '0;
            end else if (i_ctl.add) begin
                r_acc[k] <= sum[k];
            end
        end
    end

    `PTMB_ASSERT_NOW(a_acc_ctl_excl, i_clk, i_rst_n, i_ctl.clr, !i_ctl.add)

endmodule

/* dv/palette_texture_mipmap_builder_checker.sv */
`timescale 1ns / 1ps
// checker of the mip chain builder: predicts every reply and compares it on the result channel
module palette_texture_mipmap_builder_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [ptmb_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [1:0]                      i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [31:0]                     i_m_tdata,
    input  logic [0:0]                      i_m_tuser,
    input  logic                            i_cfg_we,
    input  logic [ptmb_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [ptmb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import ptmb_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        status;
    } t_texel_reply;

    t_texel_reply replies [$];
    bit [23:0]    palette_mem [PALETTE_DEPTH];
    bit [31:0]    texel_mem [STORE_DEPTH];
    logic [3:0]   size_reg = 4'd8;
    logic [1:0]   mode_reg = MODE_KEYED;
    logic         mip_en_reg = 1'b1;
    int           fails = 0;

    // oversized sizes saturate
    function automatic int effective_lg();
        return (int'(size_reg) > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : int'(size_reg);
    endfunction

    // 2x2 box average of every level below the base, each channel floored
    function automatic void box_filter_chain();
        int          dims;
        int          src;
        int          dst;
        int          half;
        int          base;
        int          sum;
        logic [31:0] p00, p01, p10, p11, w;
        dims = 1 << effective_lg();
        src  = 0;
        while (dims > 1) begin
            dst  = src + dims * dims;
            half = dims / 2;
            for (int y = 0; y < half; y++) begin
                for (int x = 0; x < half; x++) begin
                    base = src + 2 * y * dims + 2 * x;
                    p00  = texel_mem[base];
                    p01  = texel_mem[base + 1];
                    p10  = texel_mem[base + dims];
                    p11  = texel_mem[base + dims + 1];
                    for (int c = 0; c < 4; c++) begin
                        sum = int'(p00[8*c +: 8]) + int'(p01[8*c +: 8]) +
                              int'(p10[8*c +: 8]) + int'(p11[8*c +: 8]);
                        w[8*c +: 8] = 8'(sum >> 2);
                    end
                    texel_mem[dst + y * half + x] = w;
                end
            end
            src  = dst;
            dims = half;
        end
    endfunction

    function automatic t_texel_reply texel_reply(input logic [1:0] kind,
                                                 input logic [IN_DATA_W-1:0] d);
        t_texel_reply rep;
        int           lg;
        int           addr;
        int           idx;
        logic [23:0]  colour;
        logic [31:0]  word;
        rep    = '0;
        lg     = effective_lg();
        addr   = int'(d[OFF_ADDR +: ADDR_W]);
        idx    = int'(d[OFF_IDX +: 8]);
        colour = (idx < PALETTE_DEPTH) ? palette_mem[idx] : 24'h0;
        case (kind)
            KIND_PAL: begin
                if (idx < PALETTE_DEPTH) begin
                    palette_mem[idx] = {d[OFF_RED +: 8], d[OFF_GREEN +: 8], d[OFF_BLUE +: 8]};
                end else begin
                    rep.status = 1'b1;
                end
            end
            KIND_PIX: begin
                if (addr < (1 << (2 * lg))) begin
                    case (mode_reg)
                        MODE_KEYED: begin
                            word = {8'h00, colour};
                            if (word != 32'h0) word[31:24] = 8'hff;
                        end
                        MODE_ALPHA: word = {d[OFF_ALPHA +: 8], colour};
                        default:    word = d[OFF_DIR +: 32];
                    endcase
                    texel_mem[addr] = word;
                end else begin
                    rep.status = 1'b1;
                end
            end
            KIND_BUILD: begin
                if (mip_en_reg) box_filter_chain();
            end
            default: begin
                if (addr < ((1 << (2 * (lg + 1))) - 1) / 3) rep.value = texel_mem[addr];
                else rep.status = 1'b1;
            end
        endcase
        return rep;
    endfunction

    always @(posedge i_clk) begin : watch
        t_texel_reply want;
        if (!i_rst_n) begin
            size_reg   = 4'd8;
            mode_reg   = MODE_KEYED;
            mip_en_reg = 1'b1;
            replies.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SIZE_LOG2:   size_reg   = i_cfg_wdata;
                    CFG_SOURCE_MODE: mode_reg   = i_cfg_wdata[1:0];
                    CFG_MIPMAP_EN:   mip_en_reg = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            // older replies leave before the newly accepted item is queued
            if (i_m_tvalid && i_m_tready) begin
                if (replies.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("unexpected reply: value %08h status %0d",
                                 i_m_tdata, i_m_tuser[0]);
                    end
                end else begin
                    want = replies.pop_front();
                    if (i_m_tdata !== want.value || i_m_tuser[0] !== want.status) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("reply mismatch: expected value %08h status %0d, %s",
                                     want.value, want.status, "got");
                            $display("    value %08h status %0d",
                                     i_m_tdata, i_m_tuser[0]);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) replies.push_back(texel_reply(i_s_tuser, i_s_tdata));
            o_pending <= replies.size();
        end
        o_fail_count <= fails;
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// top of the mip chain builder testbench: clock, reset, stimulus and the verdict
module tb;
    import ptmb_pkg::*;

    localparam int         TIMEOUT_CYCLES = 1_500_000;
    localparam int         SETTLE_CYCLES  = 8;
    localparam int         DRAIN_CYCLES   = 16;
    localparam int         RANDOM_ITEMS   = 700;
    localparam int         ADDR_TOP       = (1 << ADDR_W) - 1;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    // tdata: address, color_index, red, green, blue, alpha, direct_color from bit 0 up
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    // tuser: kind
    logic [1:0]            i_s_tuser   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    // tdata: pixel_value
    logic [31:0]           o_m_tdata;
    // tuser: status
    logic [0:0]            o_m_tuser;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    int fail_count;
    int replies_pending;
    int cycle_count = 0;
    int stall_left  = 0;
    bit no_idle     = 1'b0;

    // what the stimulus knows about the block: which words and entries hold known data,
    // so that nothing undefined is ever read back
    bit   word_defined [STORE_DEPTH];
    int   defined_words [$];
    bit   entry_defined [PALETTE_DEPTH];
    int   defined_entries [$];
    int   cur_lg     = 8;
    logic cur_en     = 1'b1;
    int   items_sent = 0;
    int   big_builds = 0;

    palette_texture_mipmap_builder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    palette_texture_mipmap_builder_checker u_reply_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (replies_pending)
    );

    always #2 i_clk = ~i_clk;

    // watchdog: generous against the slowest run including the large builds
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("palette_texture_mipmap_builder_core regression: fail");
            $finish;
        end
    end

    // result side back-pressure: after each transaction ready may be held low for a randomly drawn stall
    always @(posedge i_clk) begin : ready_stall
        int draw;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left <= 0;
        end else if (i_m_tready) begin
            if (o_m_tvalid && !no_idle) begin
                draw = $urandom_range(0, 8);
                if (draw != 0) begin
                    i_m_tready <= 1'b0;
                    stall_left <= draw - 1;
                end
            end
        end else if (stall_left == 0) begin
            i_m_tready <= 1'b1;
        end else begin
            stall_left <= stall_left - 1;
        end
    end

    function automatic int chain_len(input int lg);
        return ((1 << (2 * (lg + 1))) - 1) / 3;
    endfunction

    // one item onto the input stream; returns at the edge of its transaction with valid
    // still high, so a back-to-back item needs only one assignment per edge
    task automatic push_item(input logic [1:0] kind, input int addr, input int idx,
                             input logic [23:0] rgb, input logic [7:0] alpha,
                             input logic [31:0] direct);
        int                   gap;
        logic [IN_DATA_W-1:0] word;
        gap  = no_idle ? 0 : $urandom_range(0, 8);
        word = '0;
        word[OFF_ADDR  +: ADDR_W] = addr[ADDR_W-1:0];
        word[OFF_IDX   +: 8]      = idx[7:0];
        word[OFF_RED   +: 8]      = rgb[23:16];
        word[OFF_GREEN +: 8]      = rgb[15:8];
        word[OFF_BLUE  +: 8]      = rgb[7:0];
        word[OFF_ALPHA +: 8]      = alpha;
        word[OFF_DIR   +: 32]     = direct;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        i_s_tuser  <= kind;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // lower valid and wait until every reply is back
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (replies_pending != 0) @(posedge i_clk);
    endtask

    task automatic program_texture(input logic [3:0] lg_reg, input logic [1:0] mode,
                                   input logic en);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_SIZE_LOG2;
        i_cfg_wdata <= lg_reg;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_SOURCE_MODE;
        i_cfg_wdata <= CFG_DATA_W'(mode);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_MIPMAP_EN;
        i_cfg_wdata <= CFG_DATA_W'(en);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_lg = (int'(lg_reg) > MAX_SIZE_LOG2) ? MAX_SIZE_LOG2 : int'(lg_reg);
        cur_en = en;
    endtask

    function automatic void mark_word(input int addr);
        if (!word_defined[addr]) begin
            word_defined[addr] = 1'b1;
            defined_words.push_back(addr);
        end
    endfunction

    function automatic int pick_entry();
        return defined_entries[$urandom_range(0, defined_entries.size() - 1)];
    endfunction

    task automatic write_entry(input int idx, input logic [23:0] rgb);
        push_item(KIND_PAL, $urandom_range(0, ADDR_TOP), idx, rgb,
                  8'($urandom_range(0, 255)), $urandom());
        if (!entry_defined[idx]) begin
            entry_defined[idx] = 1'b1;
            defined_entries.push_back(idx);
        end
    endtask

    task automatic write_texel(input int addr, input int idx, input logic [7:0] alpha,
                               input logic [31:0] direct);
        push_item(KIND_PIX, addr, idx, 24'($urandom()), alpha, direct);
        if (addr < (1 << (2 * cur_lg))) mark_word(addr);
    endtask

    task automatic read_word(input int addr);
        push_item(KIND_READ, addr, $urandom_range(0, 255), 24'($urandom()),
                  8'($urandom_range(0, 255)), $urandom());
    endtask

    // a mip word is known only where all four of its source words are known;
    // a build over unknown sources spoils a word that was known before
    task automatic issue_build();
        int dims;
        int src;
        int dst;
        int half;
        int base;
        push_item(KIND_BUILD, $urandom_range(0, ADDR_TOP), $urandom_range(0, 255),
                  24'($urandom()), 8'($urandom_range(0, 255)), $urandom());
        if (cur_lg >= 7) big_builds++;
        if (cur_en) begin
            dims = 1 << cur_lg;
            src  = 0;
            while (dims > 1) begin
                dst  = src + dims * dims;
                half = dims / 2;
                for (int y = 0; y < half; y++) begin
                    for (int x = 0; x < half; x++) begin
                        base = src + 2 * y * dims + 2 * x;
                        if (word_defined[base] && word_defined[base + 1] &&
                            word_defined[base + dims] && word_defined[base + dims + 1]) begin
                            mark_word(dst + y * half + x);
                        end else begin
                            word_defined[dst + y * half + x] = 1'b0;
                        end
                    end
                end
                src  = dst;
                dims = half;
            end
        end
    endtask

    // read a known word, alternating between a random address in the chain and one
    // remembered from earlier writes; an address past the chain end is fine as well
    task automatic read_defined();
        int addr;
        int span;
        int tries;
        bit found;
        span  = chain_len(cur_lg);
        found = 1'b0;
        addr  = 0;
        for (tries = 0; tries < 8 && !found; tries++) begin
            if (tries % 2 == 0 || defined_words.size() == 0) begin
                addr = $urandom_range(0, span - 1);
            end else begin
                addr = defined_words[$urandom_range(0, defined_words.size() - 1)];
            end
            found = (addr >= span) || word_defined[addr];
        end
        if (!found) addr = $urandom_range(span, ADDR_TOP);
        read_word(addr);
    endtask

    task automatic random_phase();
        int pick;
        int lg_reg;
        int area;
        int n;
        pick = $urandom_range(0, 99);
        // mostly small textures; the largest ones are slow to build
        if (pick < 6)       lg_reg = 0;
        else if (pick < 70) lg_reg = $urandom_range(1, 3);
        else if (pick < 88) lg_reg = $urandom_range(4, 5);
        else if (pick < 96) lg_reg = $urandom_range(6, 8);
        else                lg_reg = $urandom_range(9, 15);
        program_texture(lg_reg[3:0], 2'($urandom_range(0, 3)), $urandom_range(0, 4) != 0);
        no_idle = ($urandom_range(0, 3) == 0);
        area    = 1 << (2 * cur_lg);
        // well-formed sequence: fill the whole base, build, then ten reads of known words
        if (cur_lg <= 3 && $urandom_range(0, 1) == 1) begin
            for (int a = 0; a < area; a++) begin
                write_texel(a, pick_entry(), 8'($urandom_range(0, 255)), $urandom());
            end
            issue_build();
            repeat (10) read_defined();
        end
        n = $urandom_range(30, 60);
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                write_entry($urandom_range(0, 255),
                            ($urandom_range(0, 6) == 0) ? 24'h0 : 24'($urandom()));
            end else if (pick < 50) begin
                if ($urandom_range(0, 9) == 0) begin
                    write_texel($urandom_range(area, ADDR_TOP), pick_entry(),
                                8'($urandom_range(0, 255)), $urandom());
                end else begin
                    write_texel($urandom_range(0, area - 1), pick_entry(),
                                8'($urandom_range(0, 255)), $urandom());
                end
            end else if (pick < 54 && (cur_lg < 7 || big_builds < 2)) begin
                issue_build();
            end else if ($urandom_range(0, 6) == 0) begin
                read_word($urandom_range(chain_len(cur_lg), ADDR_TOP));
            end else begin
                read_defined();
            end
        end
    endtask

    initial begin
        int target;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 2x2 base, black-keyed palette: black entry, white entry, a colour entry, a dim non-black entry
        program_texture(4'd1, MODE_KEYED, 1'b1);
        write_entry(0, 24'h000000);
        write_entry(255, 24'hffffff);
        write_entry(1, 24'h123456);
        write_entry(2, 24'h000001);
        write_texel(0, 0, 8'h00, 32'h0);
        write_texel(1, 255, 8'hff, 32'hffff_ffff);
        write_texel(2, 2, 8'h00, 32'h0);
        write_texel(3, 1, 8'h7f, 32'h1234_5678);
        // pixel just past the base
        write_texel(4, 1, 8'h00, 32'h0);
        issue_build();
        read_word(0);
        read_word(1);
        read_word(2);
        read_word(4);
        // a later palette change must leave the stored pixel alone
        write_entry(1, 24'h654321);
        read_word(3);
        // first address past the chain, and the top of the address field
        read_word(5);
        read_word(ADDR_TOP);

        // 1x1 base with per-pixel alpha: build has nothing to do
        program_texture(4'd0, MODE_ALPHA, 1'b1);
        write_texel(0, 1, 8'h80, 32'h0);
        write_texel(1, 1, 8'h80, 32'h0);
        issue_build();
        read_word(0);

        // oversized size saturates, source mode 3 acts as direct, build disabled
        program_texture(4'd15, 2'd3, 1'b0);
        write_texel(65535, 0, 8'h00, 32'hffff_ffff);
        write_texel(65536, 0, 8'h00, 32'h0);
        read_word(65535);
        issue_build();

        program_texture(4'd2, MODE_DIRECT, 1'b1);
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) random_phase();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && replies_pending == 0) begin
            $display("palette_texture_mipmap_builder_core regression: pass");
        end else begin
            $display("palette_texture_mipmap_builder_core regression: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/ptmb_pkg.sv
rtl/ptmb_acc.sv
rtl/palette_texture_mipmap_builder_core.sv
dv/palette_texture_mipmap_builder_checker.sv
dv/tb.sv
